>>> design/tfs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the typed field serializer
// no dependencies

package tfs_pkg;

    // write kinds carried on the input tuser field
    typedef enum logic [2:0] {
        MODE_BYTE  = 3'd0,
        MODE_SHORT = 3'd1,
        MODE_INT   = 3'd2,
        MODE_LONG  = 3'd3,
        MODE_BOOL  = 3'd4,
        MODE_VINT  = 3'd5,
        MODE_FLUSH = 3'd6
    } mode_t;

    // longest byte run one write can cause: held byte plus eight long bytes
    localparam int JOB_BYTES   = 9;
    localparam int JOB_CNT_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    // vint range limits
    localparam logic signed [31:0] VINT_NEG_1 = -32'sd63;
    localparam logic signed [31:0] VINT_NEG_2 = -32'sd8191;
    localparam logic signed [31:0] VINT_NEG_3 = -32'sd1048575;
    localparam logic signed [31:0] VINT_NEG_4 = -32'sd134217727;
    localparam logic signed [31:0] VINT_POS_1 = 32'sd63;
    localparam logic signed [31:0] VINT_POS_2 = 32'sh2000;
    localparam logic signed [31:0] VINT_POS_3 = 32'sh100000;
    localparam logic signed [31:0] VINT_POS_4 = 32'sh7FFFFFF;

    // one run of wire bytes, first byte to send in the lowest lane
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]      count;
    } job_t;

endpackage

>>> design/tfs_front.sv
`timescale 1ns / 1ps
// front end: accepts typed writes, keeps the boolean packing state and
// turns each write into a byte run; depends on tfs_pkg

module tfs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          mode,
    input  logic signed [63:0]  value_in,
    output logic                push,
    output tfs_pkg::job_t       job
);

    logic [7:0]        held_reg;
    logic [7:0]        held_next;
    logic [2:0]        pos_reg;
    logic [2:0]        pos_next;
    logic [7:0][7:0]   item;
    logic [3:0]        item_cnt;
    logic              typed;
    logic [7:0]        held_new;
    logic [31:0]       vu;
    logic signed [31:0] vs;
    logic              vneg;
    logic [2:0]        vlen;

    // vint length class
    always_comb
    begin
        vu   = value_in[31:0];
        vs   = value_in[31:0];
        vneg = vu[31];
        if (vneg)
        begin
            if (vs >= tfs_pkg::VINT_NEG_1)      vlen = 3'd1;
            else if (vs >= tfs_pkg::VINT_NEG_2) vlen = 3'd2;
            else if (vs >= tfs_pkg::VINT_NEG_3) vlen = 3'd3;
            else if (vs >= tfs_pkg::VINT_NEG_4) vlen = 3'd4;
            else                                vlen = 3'd5;
        end
        else
        begin
            if (vs <= tfs_pkg::VINT_POS_1)      vlen = 3'd1;
            else if (vs < tfs_pkg::VINT_POS_2)  vlen = 3'd2;
            else if (vs < tfs_pkg::VINT_POS_3)  vlen = 3'd3;
            else if (vs <= tfs_pkg::VINT_POS_4) vlen = 3'd4;
            else                                vlen = 3'd5;
        end
    end

    // classify the write and build its byte run
    always_comb
    begin
        item      = '0;
        item_cnt  = 4'd0;
        typed     = 1'b0;
        held_next = held_reg;
        pos_next  = pos_reg;
        held_new  = held_reg | (8'(value_in[0]) << pos_reg);
        job       = '0;
        unique case (mode)
            tfs_pkg::MODE_BOOL:
            begin
                pos_next = pos_reg + 3'd1;
                if (pos_reg == 3'd7)
                begin
                    job.bytes[0] = held_new;
                    job.count    = 4'd1;
                    held_next    = 8'd0;
                end
                else
                begin
                    held_next = held_new;
                end
            end
            tfs_pkg::MODE_FLUSH:
            begin
                job.bytes[0] = held_reg;
                job.count    = (pos_reg != 3'd0) ? 4'd1 : 4'd0;
                held_next    = 8'd0;
                pos_next     = 3'd0;
            end
            tfs_pkg::MODE_BYTE:
            begin
                typed    = 1'b1;
                item[0]  = value_in[7:0];
                item_cnt = 4'd1;
            end
            tfs_pkg::MODE_SHORT:
            begin
                typed    = 1'b1;
                item[0]  = value_in[15:8];
                item[1]  = value_in[7:0];
                item_cnt = 4'd2;
            end
            tfs_pkg::MODE_INT:
            begin
                typed    = 1'b1;
                item[0]  = value_in[31:24];
                item[1]  = value_in[23:16];
                item[2]  = value_in[15:8];
                item[3]  = value_in[7:0];
                item_cnt = 4'd4;
            end
            tfs_pkg::MODE_LONG:
            begin
                typed = 1'b1;
                for (int i = 0; i < 8; i++)
                begin
                    item[i] = value_in[63-8*i -: 8];
                end
                item_cnt = 4'd8;
            end
            tfs_pkg::MODE_VINT:
            begin
                typed    = 1'b1;
                item_cnt = {1'b0, vlen};
                // head byte: sign at 0x40, continuation at 0x80
                item[0]  = {vlen != 3'd1, vneg, vu[5:0]};
                item[1]  = {vlen > 3'd2, vu[12:6]};
                item[2]  = {vlen > 3'd3, vu[19:13]};
                item[3]  = {vlen > 3'd4, vu[26:20]};
                item[4]  = {4'd0, vu[30:27]};
            end
            default:
            begin
                job = '0;
            end
        endcase

        // a typed write sends any held boolean byte first
        if (typed)
        begin
            if (pos_reg != 3'd0)
            begin
                job.bytes = {item, held_reg};
                job.count = item_cnt + 4'd1;
            end
            else
            begin
                job.bytes = {8'd0, item};
                job.count = item_cnt;
            end
            held_next = 8'd0;
            pos_next  = 3'd0;
        end
    end

    assign push = accept && (job.count != '0);

    // boolean packing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 8'd0;
            pos_reg  <= 3'd0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
        end
    end

    // a flush, vint or long write leaves nothing held
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == tfs_pkg::MODE_FLUSH || mode == tfs_pkg::MODE_VINT
                   || mode == tfs_pkg::MODE_LONG)
        |=> pos_reg == 3'd0 && held_reg == 8'd0)
        else $error("boolean state not cleared");

    // no run is longer than the held byte plus eight bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> job.count <= 4'(tfs_pkg::JOB_BYTES))
        else $error("byte run too long");

endmodule

>>> design/tfs_queue.sv
`timescale 1ns / 1ps
// short queue of byte runs between front and back end
// depends on tfs_pkg

module tfs_queue
#(
    parameter int DEPTH = tfs_pkg::QUEUE_DEPTH   // at least 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tfs_pkg::job_t wr_data,
    input  logic          pop,
    output tfs_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfs_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // never written when full unless also popped, never read when empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && !(pop && empty))
        else $error("queue overflow or underflow");

endmodule

>>> design/tfs_back.sv
`timescale 1ns / 1ps
// back end: sends the queued byte runs one byte per transfer
// depends on tfs_pkg

module tfs_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  tfs_pkg::job_t job,
    input  logic          job_avail,
    output logic          pop,
    output logic [7:0]    out_byte,
    output logic          out_valid,
    output logic          out_last,
    input  logic          out_ready
);

    logic [tfs_pkg::JOB_BYTES-1:0][7:0] cur_bytes_reg;
    logic [tfs_pkg::JOB_CNT_W-1:0]      cur_rem_reg;
    logic                               cur_valid_reg;
    logic [7:0]                         out_byte_reg;
    logic                               out_last_reg;
    logic                               out_valid_reg;
    logic                               advance;
    logic                               cur_last;

    assign advance  = cur_valid_reg && (!out_valid_reg || out_ready);
    assign cur_last = (cur_rem_reg == tfs_pkg::JOB_CNT_W'(1));
    assign pop      = job_avail && (!cur_valid_reg || (advance && cur_last));

    // current run: shift one byte out per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_rem_reg   <= '0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            cur_rem_reg   <= job.count;
        end
        else if (advance)
        begin
            cur_valid_reg <= !cur_last;
            cur_rem_reg   <= cur_rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_bytes_reg <= job.bytes;
        end
        else if (advance)
        begin
            cur_bytes_reg <= {8'd0, cur_bytes_reg[tfs_pkg::JOB_BYTES-1:1]};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= cur_bytes_reg[0];
            out_last_reg <= cur_last;
        end
    end

    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

    // a live run always has bytes left
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_rem_reg != '0)
        else $error("empty run in progress");

endmodule

>>> design/typed_field_serializer_top.sv
`timescale 1ns / 1ps
// typed field serializer: one typed write in, its wire bytes out
// a write's bytes pass the run queue, current run and output registers
// throughput: one byte per cycle at the output register while m_axis_tready
// is high and runs are queued; a write causes 0 to 9 bytes
// input transfers go on every cycle while the run queue has room
// reset: rst_n async active low, clears boolean state, queue and output
// depends on tfs_pkg, tfs_front, tfs_queue, tfs_back

module typed_field_serializer_top
#(
    parameter int QUEUE_DEPTH = tfs_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic signed [63:0] s_axis_tdata,   // value_in
    input  logic [2:0]         s_axis_tuser,   // mode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // out_byte
    output logic               m_axis_tlast    // last_byte
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    tfs_pkg::job_t wr_job;
    tfs_pkg::job_t rd_job;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // classify writes
    tfs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .mode     (s_axis_tuser),
        .value_in (s_axis_tdata),
        .push     (push),
        .job      (wr_job)
    );

    // decoupling queue
    tfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_job),
        .pop     (pop),
        .rd_data (rd_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    // byte sender
    tfs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (rd_job),
        .job_avail (!q_empty),
        .pop       (pop),
        .out_byte  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for typed_field_serializer_top: drives typed writes, predicts
// the wire bytes in order and compares every output transfer field by field
// depends on tfs_pkg and typed_field_serializer_top

module tb_top;

    // mode code outside the defined set, the block must ignore it
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // vint size limits, signed view of the low 32 bits
    localparam int VINT_ONE_NEG = -63;
    localparam int VINT_ONE_POS = 63;
    localparam int VINT_TWO_NEG = -8191;
    localparam int VINT_TWO_POS = 'h2000;
    localparam int VINT_THREE_NEG = -1048575;
    localparam int VINT_THREE_POS = 'h100000;
    localparam int VINT_FOUR_NEG = -134217727;
    localparam int VINT_FOUR_POS = 'h7FFFFFF;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [63:0] s_axis_tdata = '0;   // value_in
    logic [2:0]         s_axis_tuser = '0;   // mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // out_byte
    logic               m_axis_tlast;        // last_byte

    // predictor state: boolean bits collected so far
    logic [7:0] held_bits = '0;
    logic [2:0] bit_pos = '0;

    wire_byte_t wire_q[$];
    wire_byte_t next_byte;
    int         error_count = 0;
    int         byte_index = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;

    typed_field_serializer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void push_wire_byte(input logic [7:0] data, input logic last);
        wire_byte_t b;
        b.data = data;
        b.last = last;
        wire_q.push_back(b);
    endfunction

    // bytes caused by one typed write, appended to wire_q
    function automatic void predict_write(input logic [2:0] mode, input logic [63:0] value);
        logic [31:0] u;
        int          sval;
        int          nbytes;
        int          k;
        logic [7:0]  codes[5];
        u = value[31:0];
        sval = $signed(u);
        nbytes = 0;
        k = 0;

        // boolean bits pack low bit first, byte leaves on its eighth bit
        if (mode == tfs_pkg::MODE_BOOL)
        begin
            held_bits[bit_pos] = value[0];
            bit_pos = bit_pos + 3'd1;
            if (bit_pos == 3'd0)
            begin
                push_wire_byte(held_bits, 1'b1);
                held_bits = '0;
            end
            return;
        end

        if (mode == tfs_pkg::MODE_FLUSH)
        begin
            if (bit_pos != 3'd0)
                push_wire_byte(held_bits, 1'b1);
            held_bits = '0;
            bit_pos = '0;
            return;
        end

        if (mode > tfs_pkg::MODE_FLUSH)
            return;

        // a partly filled boolean byte goes out ahead of any typed write
        if (bit_pos != 3'd0)
            push_wire_byte(held_bits, 1'b0);
        held_bits = '0;
        bit_pos = '0;

        case (mode)
            tfs_pkg::MODE_BYTE:  nbytes = 1;
            tfs_pkg::MODE_SHORT: nbytes = 2;
            tfs_pkg::MODE_INT:   nbytes = 4;
            tfs_pkg::MODE_LONG:  nbytes = 8;
            default:             nbytes = 0;
        endcase

        // fixed widths, big-endian
        if (nbytes != 0)
        begin
            for (int i = nbytes - 1; i >= 0; i--)
                push_wire_byte(value[8*i +: 8], i == 0);
            return;
        end

        // vint: short forms first, then continuation chain
        if (u[31] && sval >= VINT_ONE_NEG)
        begin
            push_wire_byte({2'b01, u[5:0]}, 1'b1);
            return;
        end
        if (!u[31] && sval <= VINT_ONE_POS)
        begin
            push_wire_byte({2'b00, u[5:0]}, 1'b1);
            return;
        end
        if (u[31] ? sval >= VINT_TWO_NEG : sval < VINT_TWO_POS)
            k = 2;
        else if (u[31] ? sval >= VINT_THREE_NEG : sval < VINT_THREE_POS)
            k = 3;
        else if (u[31] ? sval >= VINT_FOUR_NEG : sval <= VINT_FOUR_POS)
            k = 4;
        else
            k = 5;
        codes[0] = {1'b1, u[31], u[5:0]};
        codes[1] = {k > 2, u[12:6]};
        codes[2] = {k > 3, u[19:13]};
        codes[3] = {k > 4, u[26:20]};
        codes[4] = {4'b0000, u[30:27]};
        for (int i = 0; i < k; i++)
            push_wire_byte(codes[i], i == k - 1);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t ns, byte %0d: %s", $time, byte_index, what);
    endtask

    // one input transfer, with random idle cycles ahead of it
    task automatic send_write(input logic [2:0] mode, input logic [63:0] value);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_write(mode, value);
    endtask

    // output side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // compare each output transfer with the oldest predicted byte
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (wire_q.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          m_axis_tdata, m_axis_tlast));
            else
            begin
                next_byte = wire_q.pop_front();
                if (m_axis_tdata !== next_byte.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_axis_tdata, next_byte.data));
                if (m_axis_tlast !== next_byte.last)
                    report_mismatch($sformatf("last_byte %0b, want %0b",
                                              m_axis_tlast, next_byte.last));
            end
            byte_index++;
        end
    end

    // vint values near the size boundaries, small or fully random, random upper half
    function automatic logic [63:0] vint_value();
        int lo;
        case ($urandom_range(0, 3))
            0:
            begin
                lo = (1 << (6 + 7 * $urandom_range(0, 3))) + $urandom_range(0, 3) - 2;
                if ($urandom_range(0, 1))
                    lo = -lo;
            end
            1:       lo = $urandom_range(0, 255) - 128;
            default: lo = $urandom;
        endcase
        return {$urandom, lo};
    endfunction

    task automatic test_fixed_width();
        send_write(tfs_pkg::MODE_BYTE, 64'h0123_4567_89AB_CD7F);
        send_write(tfs_pkg::MODE_SHORT, 64'hFFFF_FFFF_FFFF_8000);
        send_write(tfs_pkg::MODE_INT, 64'h7FFF_FFFF_8000_0001);
        send_write(tfs_pkg::MODE_LONG, 64'h8000_0000_0000_0000);
        send_write(tfs_pkg::MODE_LONG, 64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_vint_ranges();
        // -64 needs two bytes, -63 still fits in one
        send_write(tfs_pkg::MODE_VINT, 64'hA5A5_A5A5_FFFF_FFC0);
        send_write(tfs_pkg::MODE_VINT, 64'h5A5A_5A5A_FFFF_FFC1);
        send_write(tfs_pkg::MODE_VINT, 64'h0000_0000_0000_0040);
        send_write(tfs_pkg::MODE_VINT, 64'hFFFF_FFFF_07FF_FFFF);
        send_write(tfs_pkg::MODE_VINT, 64'h0000_0000_8000_0000);
    endtask

    task automatic test_bool_packing();
        // full byte of booleans
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(tfs_pkg::MODE_BOOL, 64'd0);
        send_write(tfs_pkg::MODE_BOOL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(tfs_pkg::MODE_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(tfs_pkg::MODE_BOOL, 64'd0);
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        // held partial byte ahead of a typed write
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(tfs_pkg::MODE_BOOL, 64'd0);
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(tfs_pkg::MODE_BYTE, 64'h0000_0000_0000_00A5);
    endtask

    task automatic test_ignored_writes();
        send_write(tfs_pkg::MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        // unused mode must leave the held bits alone
        send_write(tfs_pkg::MODE_BOOL, 64'd1);
        send_write(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_write(tfs_pkg::MODE_FLUSH, 64'd0);
    endtask

    task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n_items);
        int sent;
        int pick;
        int run;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                run = $urandom_range(1, 12);
                repeat (run)
                    send_write(tfs_pkg::MODE_BOOL, {$urandom, $urandom});
                sent += run;
            end
            else if (pick < 31)
            begin
                send_write(tfs_pkg::MODE_FLUSH, {$urandom, $urandom});
                sent++;
            end
            else if (pick < 34)
                send_write(MODE_UNUSED, {$urandom, $urandom});
            else if (pick < 60)
            begin
                send_write(tfs_pkg::MODE_VINT, vint_value());
                sent++;
            end
            else
            begin
                send_write(3'($urandom_range(tfs_pkg::MODE_BYTE, tfs_pkg::MODE_LONG)),
                           {$urandom, $urandom});
                sent++;
            end
        end
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fixed_width();
        test_vint_ranges();
        test_bool_packing();
        test_ignored_writes();

        test_random_mix(0, 0, 38);
        test_random_mix(61, 0, 38);
        test_random_mix(0, 61, 38);
        test_random_mix(25, 25, 38);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray bytes
        while (wire_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> typed_field_serializer_top.f
design/tfs_pkg.sv
design/tfs_front.sv
design/tfs_queue.sv
design/tfs_back.sv
design/typed_field_serializer_top.sv
tb/sv/tb_top.sv
